@@ design/tif_pkg.sv @@
// Shared types and constants for the timed item FIFO.
// No dependencies; used by tif_seq and timed_item_fifo_unit.

package tif_pkg;

   // Field widths of one queue entry, of the operation code and of the reported count
   localparam int CLASS_W     = 2;
   localparam int COUNT_W     = 16;
   localparam int ENTRY_W     = CLASS_W + COUNT_W;
   localparam int OP_W        = 2;
   localparam int COUNT_OUT_W = 4;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   // Report for an empty queue
   localparam logic [CLASS_W-1:0] EMPTY_CLASS     = 2'd0;
   localparam logic [COUNT_W-1:0] EMPTY_COUNTDOWN = 16'd1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_READ,
      ST_DONE
   } state_type;

   // Entry memory port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

endpackage

@@ design/tif_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module tif_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register one read; hold read data when not reading
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tif_seq.sv @@
// Sequencer of the timed item FIFO: pointers, occupancy, the countdown walk
// over the entry memory and the result register. Uses tif_pkg.

module tif_seq #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tif_pkg::OP_W-1:0]             req_op,
   input  logic [tif_pkg::CLASS_W-1:0]          req_box_class,
   input  logic [tif_pkg::COUNT_W-1:0]          req_delay_ms,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tif_pkg::CLASS_W-1:0]          rsp_front_class,
   output logic [tif_pkg::COUNT_W-1:0]          rsp_front_countdown,
   output logic [tif_pkg::COUNT_OUT_W-1:0]      rsp_entry_count,
   output logic                                 rsp_push_dropped,
   // entry memory
   output tif_pkg::ram_ctl_type                 ram_ctl,
   output logic [$clog2(QUEUE_DEPTH)-1:0]       ram_wr_addr,
   output logic [tif_pkg::ENTRY_W-1:0]          ram_wr_data,
   output logic [$clog2(QUEUE_DEPTH)-1:0]       ram_rd_addr,
   input  logic [tif_pkg::ENTRY_W-1:0]          ram_rd_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

   tif_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             dropped_ff, dropped_in;
   logic [PTR_W-1:0] tick_ptr_ff, tick_ptr_in;
   logic [OCC_W-1:0] tick_left_ff, tick_left_in;
   logic             wb_valid_ff, wb_valid_in;
   logic [PTR_W-1:0] wb_addr_ff, wb_addr_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_load;
   logic [tif_pkg::CLASS_W-1:0]     rsp_class_ff, rsp_class_in;
   logic [tif_pkg::COUNT_W-1:0]     rsp_countdown_ff, rsp_countdown_in;
   logic [tif_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                            rsp_dropped_ff, rsp_dropped_in;

   logic [tif_pkg::COUNT_W-1:0]     rd_countdown;
   logic [tif_pkg::CLASS_W-1:0]     rd_class;
   logic [tif_pkg::COUNT_W-1:0]     dec_countdown;
   logic                            out_free;

   // Wrap a pointer at the queue depth
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   assign rd_countdown  = ram_rd_data[tif_pkg::COUNT_W-1:0];
   assign rd_class      = ram_rd_data[tif_pkg::ENTRY_W-1:tif_pkg::COUNT_W];
   assign dec_countdown = (rd_countdown == '0) ? '0 : rd_countdown - 1'b1;
   assign out_free      = !rsp_valid_ff || rsp_ready;

   // Next state, memory strobes and result load
   always_comb begin
      state_in         = state_ff;
      rptr_in          = rptr_ff;
      wptr_in          = wptr_ff;
      occ_in           = occ_ff;
      dropped_in       = dropped_ff;
      tick_ptr_in      = tick_ptr_ff;
      tick_left_in     = tick_left_ff;
      wb_valid_in      = wb_valid_ff;
      wb_addr_in       = wb_addr_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_load         = 1'b0;
      req_ready        = 1'b0;
      ram_ctl          = '0;
      ram_wr_addr      = wptr_ff;
      ram_wr_data      = {req_box_class, req_delay_ms};
      ram_rd_addr      = rptr_ff;

      case (state_ff)
         tif_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dropped_in = 1'b0;
               state_in   = tif_pkg::ST_READ;
               case (req_op)
                  tif_pkg::OP_PUSH: begin
                     if (occ_ff == FULL_OCC) begin
                        dropped_in = 1'b1;
                     end else begin
                        ram_ctl.wr_en = 1'b1;
                        wptr_in       = next_ptr(wptr_ff);
                        occ_in        = occ_ff + 1'b1;
                     end
                  end
                  tif_pkg::OP_POP: begin
                     if (occ_ff != '0) begin
                        rptr_in = next_ptr(rptr_ff);
                        occ_in  = occ_ff - 1'b1;
                     end
                  end
                  tif_pkg::OP_TICK: begin
                     tick_ptr_in  = rptr_ff;
                     tick_left_in = occ_ff;
                     wb_valid_in  = 1'b0;
                     state_in     = tif_pkg::ST_TICK;
                  end
                  default: begin
                     // unused code: report status only
                  end
               endcase
            end
         end

         tif_pkg::ST_TICK: begin
            // write back the entry read last cycle, read the next one
            if (wb_valid_ff) begin
               ram_ctl.wr_en = 1'b1;
               ram_wr_addr   = wb_addr_ff;
               ram_wr_data   = {rd_class, dec_countdown};
            end
            if (tick_left_ff != '0) begin
               ram_ctl.rd_en = 1'b1;
               ram_rd_addr   = tick_ptr_ff;
               wb_valid_in   = 1'b1;
               wb_addr_in    = tick_ptr_ff;
               tick_ptr_in   = next_ptr(tick_ptr_ff);
               tick_left_in  = tick_left_ff - 1'b1;
            end else begin
               wb_valid_in = 1'b0;
               state_in    = tif_pkg::ST_READ;
            end
         end

         tif_pkg::ST_READ: begin
            ram_ctl.rd_en = 1'b1;
            state_in      = tif_pkg::ST_DONE;
         end

         tif_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tif_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tif_pkg::ST_IDLE;
         end
      endcase

      // Form the status beat from the head entry
      if (occ_ff == '0) begin
         rsp_class_in     = tif_pkg::EMPTY_CLASS;
         rsp_countdown_in = tif_pkg::EMPTY_COUNTDOWN;
      end else begin
         rsp_class_in     = rd_class;
         rsp_countdown_in = rd_countdown;
      end
      rsp_count_in   = tif_pkg::COUNT_OUT_W'(occ_ff);
      rsp_dropped_in = dropped_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tif_pkg::ST_IDLE;
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         occ_ff       <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         occ_ff       <= occ_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dropped_ff   <= dropped_in;
      tick_ptr_ff  <= tick_ptr_in;
      tick_left_ff <= tick_left_in;
      wb_addr_ff   <= wb_addr_in;
      if (rsp_load) begin
         rsp_class_ff     <= rsp_class_in;
         rsp_countdown_ff <= rsp_countdown_in;
         rsp_count_ff     <= rsp_count_in;
         rsp_dropped_ff   <= rsp_dropped_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_front_class     = rsp_class_ff;
   assign rsp_front_countdown = rsp_countdown_ff;
   assign rsp_entry_count     = rsp_count_ff;
   assign rsp_push_dropped    = rsp_dropped_ff;

endmodule

@@ design/timed_item_fifo_unit.sv @@
// Top level of the timed item FIFO: sequencer plus entry memory.
// Uses tif_pkg, tif_ram and tif_seq.

// A circular queue of QUEUE_DEPTH entries (class and 16-bit countdown) held in
// one synchronous RAM. Each request beat is a push, a pop or a tick; every
// request returns one response beat with the head class, head countdown
// (class 0 and countdown 1 when empty), the entry count (low 4 bits) and a
// flag for a push dropped on a full queue. Every request passes the read and
// done states to the response register; a tick first walks the occupied
// entries through the RAM, one read-modify-write per cycle. One request is in
// flight at a time; a finished response waits in an output register, so the
// next request is taken before it is collected.

module timed_item_fifo_unit #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tif_pkg::OP_W-1:0]             req_op,
   input  logic [tif_pkg::CLASS_W-1:0]          req_box_class,
   input  logic [tif_pkg::COUNT_W-1:0]          req_delay_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tif_pkg::CLASS_W-1:0]          rsp_front_class,
   output logic [tif_pkg::COUNT_W-1:0]          rsp_front_countdown,
   output logic [tif_pkg::COUNT_OUT_W-1:0]      rsp_entry_count,
   output logic                                 rsp_push_dropped
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   tif_pkg::ram_ctl_type          ram_ctl;
   logic [PTR_W-1:0]              ram_wr_addr;
   logic [tif_pkg::ENTRY_W-1:0]   ram_wr_data;
   logic [PTR_W-1:0]              ram_rd_addr;
   logic [tif_pkg::ENTRY_W-1:0]   ram_rd_data;

   // Queue control and response register
   tif_seq #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_seq (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_box_class       (req_box_class),
      .req_delay_ms        (req_delay_ms),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_front_class     (rsp_front_class),
      .rsp_front_countdown (rsp_front_countdown),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_push_dropped    (rsp_push_dropped),
      .ram_ctl             (ram_ctl),
      .ram_wr_addr         (ram_wr_addr),
      .ram_wr_data         (ram_wr_data),
      .ram_rd_addr         (ram_rd_addr),
      .ram_rd_data         (ram_rd_data)
   );

   // Entry store: class over countdown
   tif_ram #(
      .WIDTH(tif_pkg::ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef NO_ASSERTIONS
   // The walk never reads the entry it is writing back
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_ctl.wr_en && ram_ctl.rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("entry memory read and written at the same address");

   // A dropped push is only reported on a full queue
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_push_dropped) |->
         (rsp_entry_count == tif_pkg::COUNT_OUT_W'(QUEUE_DEPTH)))
      else $error("push dropped while queue not full");

   // An empty queue reports the idle head
   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_entry_count == '0) && (QUEUE_DEPTH < 16)) |->
         ((rsp_front_class == tif_pkg::EMPTY_CLASS) &&
          (rsp_front_countdown == tif_pkg::EMPTY_COUNTDOWN)))
      else $error("empty queue reported a head entry");

   // No new request is taken while a walk or read is under way
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in flight");
`endif

endmodule
